// ----- design/usl_pkg.sv -----
`default_nettype none

package usl_pkg;

   // fixed field widths of the request and response words
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int COORD_W  = 16;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND    = 3'd0,
      KIND_INSERT    = 3'd1,
      KIND_REMOVE_AT = 3'd2,
      KIND_REMOVE    = 3'd3,
      KIND_CLEAR     = 3'd4
   } kind_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_BAD_INDEX = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOVE
   } state_type;

endpackage

`default_nettype wire

// ----- design/undirected_segment_list.sv -----
// Ordered list of undirected segments held in one synchronous RAM.
// Clear, unknown kinds and bad indexes are answered straight from idle; append is a
// linear scan, one entry a cycle; insert and remove add a shift pass to the scan, and
// remove-at is a shift pass alone. One operation at a time; busy is high until
// the response word is issued. Reset (synchronous) empties the list; RAM is not cleared.
`default_nettype none

module undirected_segment_list #(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [usl_pkg::KIND_W-1:0]       req_kind,
   input  wire logic signed [usl_pkg::COORD_W-1:0] req_from_x,
   input  wire logic signed [usl_pkg::COORD_W-1:0] req_from_y,
   input  wire logic signed [usl_pkg::COORD_W-1:0] req_to_x,
   input  wire logic signed [usl_pkg::COORD_W-1:0] req_to_y,
   input  wire logic [usl_pkg::POS_W-1:0]        req_position,
   output logic                                  rsp_valid,
   output logic      [usl_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [usl_pkg::COUNT_W-1:0]      rsp_count
);

   localparam int DW   = 4 * COORD_BITS;
   localparam int HW   = 2 * COORD_BITS;
   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > usl_pkg::POS_W) ? CW : usl_pkg::POS_W;

   usl_pkg::state_type  state_ff, state_in;
   usl_pkg::kind_type   kind_ff, kind_in;
   usl_pkg::status_type rsp_status_ff, rsp_status_in, resp_status;
   logic [DW-1:0]       fwd_ff, fwd_in, rev;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       count_ff, count_in, count_m1;
   logic [CW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       left_ff, left_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       ridx_ff, ridx_in;
   logic [AW-1:0]       wa_ff, wa_in;
   logic                up_ff, up_in;
   logic                rv_ff, rv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [usl_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [CW+usl_pkg::COUNT_W-1:0] count_wide;

   logic                accept, match, full, req_bad, resp_fire;
   logic [CMPW-1:0]     pos_ext, count_ext;
   logic [CW-1:0]       pos_cw;

   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [DW-1:0]       mem_wr_data, mem_rd_data;

   usl_seg_mem #(
      .DEPTH  (CAPACITY),
      .DATA_W (DW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != usl_pkg::ST_IDLE);
   // reversed segment: swap the two points
   assign rev       = {fwd_ff[HW-1:0], fwd_ff[DW-1:HW]};
   assign match     = rv_ff && ((mem_rd_data == fwd_ff) || (mem_rd_data == rev));
   assign full      = (count_ff == CW'(CAPACITY));
   assign pos_ext   = CMPW'(req_position);
   assign count_ext = CMPW'(count_ff);
   assign req_bad   = (pos_ext >= count_ext);
   assign pos_cw    = pos_ext[CW-1:0];
   assign count_m1  = count_ff - CW'(1);

   // next state, memory control and response
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      fwd_in        = fwd_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      left_in       = left_ff;
      addr_in       = addr_ff;
      ridx_in       = ridx_ff;
      wa_in         = wa_ff;
      up_in         = up_ff;
      rv_in         = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wa_ff;
      mem_wr_data   = mem_rd_data;
      resp_fire     = 1'b0;
      resp_status   = usl_pkg::STATUS_DONE;

      unique case (state_ff)
         usl_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = usl_pkg::kind_type'(req_kind);
               fwd_in  = {req_to_y[COORD_BITS-1:0], req_to_x[COORD_BITS-1:0],
                          req_from_y[COORD_BITS-1:0], req_from_x[COORD_BITS-1:0]};
               pos_in  = pos_ext[AW-1:0];
               scan_in = '0;
               unique case (usl_pkg::kind_type'(req_kind))
                  usl_pkg::KIND_APPEND,
                  usl_pkg::KIND_REMOVE: begin
                     state_in = usl_pkg::ST_SEARCH;
                  end
                  usl_pkg::KIND_INSERT: begin
                     if (req_bad) begin
                        resp_fire   = 1'b1;
                        resp_status = usl_pkg::STATUS_BAD_INDEX;
                     end else begin
                        state_in = usl_pkg::ST_SEARCH;
                     end
                  end
                  usl_pkg::KIND_REMOVE_AT: begin
                     if (req_bad) begin
                        resp_fire   = 1'b1;
                        resp_status = usl_pkg::STATUS_BAD_INDEX;
                     end else begin
                        // pull later entries down over the deleted one
                        state_in = usl_pkg::ST_MOVE;
                        up_in    = 1'b0;
                        addr_in  = pos_ext[AW-1:0] + AW'(1);
                        left_in  = count_m1 - pos_cw;
                     end
                  end
                  usl_pkg::KIND_CLEAR: begin
                     count_in  = '0;
                     resp_fire = 1'b1;
                  end
                  default: begin
                     resp_fire = 1'b1;
                  end
               endcase
            end
         end

         usl_pkg::ST_SEARCH: begin
            // linear scan, one entry read per cycle, compare in the next cycle
            mem_rd_en   = (scan_ff < count_ff);
            mem_rd_addr = scan_ff[AW-1:0];
            if (mem_rd_en) begin
               scan_in = scan_ff + CW'(1);
               rv_in   = 1'b1;
               ridx_in = scan_ff[AW-1:0];
            end
            if (match || !mem_rd_en) begin
               mem_rd_en = 1'b0;
               rv_in     = 1'b0;
               state_in  = usl_pkg::ST_IDLE;
               resp_fire = 1'b1;
               unique case (kind_ff)
                  usl_pkg::KIND_APPEND: begin
                     if (match) begin
                        resp_status = usl_pkg::STATUS_DUPLICATE;
                     end else if (full) begin
                        resp_status = usl_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[AW-1:0];
                        mem_wr_data = fwd_ff;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  usl_pkg::KIND_INSERT: begin
                     if (match) begin
                        resp_status = usl_pkg::STATUS_DUPLICATE;
                     end else if (full) begin
                        resp_status = usl_pkg::STATUS_FULL;
                     end else begin
                        // push entries from the tail up to pos one place up
                        resp_fire = 1'b0;
                        state_in  = usl_pkg::ST_MOVE;
                        up_in     = 1'b1;
                        addr_in   = count_m1[AW-1:0];
                        left_in   = count_ff - CW'(pos_ff);
                     end
                  end
                  usl_pkg::KIND_REMOVE: begin
                     if (!match) begin
                        resp_status = usl_pkg::STATUS_NOT_FOUND;
                     end else begin
                        resp_fire = 1'b0;
                        state_in  = usl_pkg::ST_MOVE;
                        up_in     = 1'b0;
                        addr_in   = ridx_ff + AW'(1);
                        left_in   = count_m1 - CW'(ridx_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         usl_pkg::ST_MOVE: begin
            // read one entry a cycle, write it back one place over next cycle
            mem_rd_en   = (left_ff != '0);
            mem_rd_addr = addr_ff;
            if (mem_rd_en) begin
               left_in = left_ff - CW'(1);
               addr_in = up_ff ? addr_ff - AW'(1) : addr_ff + AW'(1);
               wa_in   = up_ff ? addr_ff + AW'(1) : addr_ff - AW'(1);
               rv_in   = 1'b1;
            end
            if (rv_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wa_ff;
               mem_wr_data = mem_rd_data;
            end
            // pass finished: drop the new word into its slot or shorten the list
            if (!mem_rd_en && !rv_ff) begin
               state_in  = usl_pkg::ST_IDLE;
               resp_fire = 1'b1;
               if (up_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pos_ff;
                  mem_wr_data = fwd_ff;
                  count_in    = count_ff + CW'(1);
               end else begin
                  count_in = count_m1;
               end
            end
         end

         default: begin
            state_in = usl_pkg::ST_IDLE;
         end
      endcase

      count_wide    = {{usl_pkg::COUNT_W{1'b0}}, count_in};
      rsp_valid_in  = resp_fire;
      rsp_status_in = resp_status;
      rsp_count_in  = count_wide[usl_pkg::COUNT_W-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= usl_pkg::ST_IDLE;
         count_ff     <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         left_ff      <= left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      fwd_ff        <= fwd_in;
      pos_ff        <= pos_in;
      addr_ff       <= addr_in;
      ridx_ff       <= ridx_in;
      wa_ff         <= wa_in;
      up_ff         <= up_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   // no read left in flight once the controller is idle
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == usl_pkg::ST_IDLE) |-> !rv_ff)
      else $error("read data pending while idle");

   // list never grows past capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count above capacity");

   // no response word without an operation
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == usl_pkg::ST_IDLE && !start) |=> !rsp_valid_ff)
      else $error("response without operation");

   // a shift never writes the entry it reads in the same cycle
   a_move_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == usl_pkg::ST_MOVE && mem_wr_en && mem_rd_en)
         |-> (mem_wr_addr != mem_rd_addr))
      else $error("shift read and write collide");

endmodule

`default_nettype wire

// ----- design/usl_seg_mem.sv -----
`default_nettype none

// segment store: one write port, one read port, registered read data
module usl_seg_mem #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- bench/segment_list_checker.sv -----
// Watches the request and response channels of the segment list, keeps its own copy
// of the list, and compares each response word with the oldest predicted one.
module segment_list_checker
   import usl_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [KIND_W-1:0]          req_kind,
   input  wire logic signed [COORD_W-1:0]  req_from_x,
   input  wire logic signed [COORD_W-1:0]  req_from_y,
   input  wire logic signed [COORD_W-1:0]  req_to_x,
   input  wire logic signed [COORD_W-1:0]  req_to_y,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic                       rsp_valid,
   input  wire logic [STATUS_W-1:0]        rsp_status,
   input  wire logic [COUNT_W-1:0]         rsp_count,
   output int                              fail_count,
   output int                              outstanding
);

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
   } list_result_type;

   // shadow of the list contents
   logic [4*COORD_W-1:0] stored_seg [CAPACITY];
   int                   stored_total;
   int                   mismatches;
   list_result_type      awaited_results [$];

   // first entry equal to the segment either way round, -1 if none
   function automatic int find_segment(logic [4*COORD_W-1:0] fwd, logic [4*COORD_W-1:0] rev);
      for (int i = 0; i < stored_total; i++)
         if (stored_seg[i] == fwd || stored_seg[i] == rev)
            return i;
      return -1;
   endfunction

   // close the gap at idx
   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < stored_total; i++)
         stored_seg[i] = stored_seg[i + 1];
      stored_total--;
   endfunction

   // apply one operation to the shadow list and return the response it should give
   function automatic list_result_type apply_operation(
      logic [KIND_W-1:0]         kind,
      logic signed [COORD_W-1:0] fx,
      logic signed [COORD_W-1:0] fy,
      logic signed [COORD_W-1:0] tx,
      logic signed [COORD_W-1:0] ty,
      logic [POS_W-1:0]          pos
   );
      logic [4*COORD_W-1:0] fwd;
      logic [4*COORD_W-1:0] rev;
      status_type           st;
      int                   hit;
      list_result_type      res;
      fwd = {ty, tx, fy, fx};
      rev = {fy, fx, ty, tx};
      st  = STATUS_DONE;
      case (kind)
         KIND_APPEND: begin
            if (find_segment(fwd, rev) >= 0)
               st = STATUS_DUPLICATE;
            else if (stored_total >= CAPACITY)
               st = STATUS_FULL;
            else begin
               stored_seg[stored_total] = fwd;
               stored_total++;
            end
         end
         KIND_INSERT: begin
            // index check wins over the duplicate check
            if (int'(pos) >= stored_total)
               st = STATUS_BAD_INDEX;
            else if (find_segment(fwd, rev) >= 0)
               st = STATUS_DUPLICATE;
            else if (stored_total >= CAPACITY)
               st = STATUS_FULL;
            else begin
               for (int i = stored_total; i > int'(pos); i--)
                  stored_seg[i] = stored_seg[i - 1];
               stored_seg[pos] = fwd;
               stored_total++;
            end
         end
         KIND_REMOVE_AT: begin
            if (int'(pos) >= stored_total)
               st = STATUS_BAD_INDEX;
            else
               drop_entry(int'(pos));
         end
         KIND_REMOVE: begin
            hit = find_segment(fwd, rev);
            if (hit < 0)
               st = STATUS_NOT_FOUND;
            else
               drop_entry(hit);
         end
         KIND_CLEAR: begin
            stored_total = 0;
         end
         default: begin
            // spare codes leave the list alone
         end
      endcase
      res.status = st;
      res.count  = COUNT_W'(stored_total);
      return res;
   endfunction

   // response first: it belongs to an earlier word than one accepted at this edge
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         stored_total = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               $error("response word with nothing expected: status %0d, count %0d",
                      rsp_status, rsp_count);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_count !== want.count) begin
                  $error("count mismatch: expected %0d, actual %0d", want.count, rsp_count);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            awaited_results.push_back(apply_operation(req_kind, req_from_x, req_from_y,
                                                      req_to_x, req_to_y, req_position));
      end
      fail_count  <= mismatches;
      outstanding <= awaited_results.size();
   end

endmodule

// ----- bench/testbench.sv -----
// Drives list operations into the segment list and gives the verdict; the checker
// beside the block does all prediction and comparison.
module testbench;
   import usl_pkg::*;

   localparam int TOTAL_ITEMS  = 1350;
   localparam int QUIET_ITEMS  = 150;
   localparam int TAIL_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [KIND_W-1:0]         req_kind;
   logic signed [COORD_W-1:0] req_from_x;
   logic signed [COORD_W-1:0] req_from_y;
   logic signed [COORD_W-1:0] req_to_x;
   logic signed [COORD_W-1:0] req_to_y;
   logic [POS_W-1:0]          req_position;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic [COUNT_W-1:0]        rsp_count;
   int                        fail_count;
   int                        outstanding;

   int                        issued = 0;
   int                        gap_odds = 0;
   int                        cycle_count = 0;
   logic [COUNT_W-1:0]        last_count = '0;
   logic signed [COORD_W-1:0] pool_x [8];
   logic signed [COORD_W-1:0] pool_y [8];

   undirected_segment_list uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_from_x   (req_from_x),
      .req_from_y   (req_from_y),
      .req_to_x     (req_to_x),
      .req_to_y     (req_to_y),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   segment_list_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_from_x   (req_from_x),
      .req_from_y   (req_from_y),
      .req_to_x     (req_to_x),
      .req_to_y     (req_to_y),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   // clock, period 20
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // rough list length, used to aim index values
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         last_count <= rsp_count;
   end

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sh0000;
         3:       return 16'shffff;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // mostly valid indexes, some anywhere, some exactly one past the end
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12)
         return (last_count == 0) ? '0 : POS_W'($urandom_range(0, int'(last_count) - 1));
      else if (r < 17)
         return POS_W'($urandom);
      else
         return last_count[POS_W-1:0];
   endfunction

   // segment from the small point pool, so duplicates and matches are common
   task automatic pool_segment(output logic signed [COORD_W-1:0] fx, fy, tx, ty);
      int a;
      int b;
      a = $urandom_range(0, 7);
      b = ($urandom_range(0, 7) == 0) ? a : $urandom_range(0, 7);
      fx = pool_x[a];
      fy = pool_y[a];
      tx = pool_x[b];
      ty = pool_y[b];
   endtask

   task automatic refill_pool();
      for (int i = 0; i < 8; i++) begin
         pool_x[i] = rand_coord();
         pool_y[i] = rand_coord();
      end
   endtask

   // present one word, hold it until accepted, then maybe drop start and idle
   task automatic issue_op(input logic [KIND_W-1:0] kind,
                           input logic signed [COORD_W-1:0] fx, fy, tx, ty,
                           input logic [POS_W-1:0] pos);
      start        = 1'b1;
      req_kind     = kind;
      req_from_x   = fx;
      req_from_y   = fy;
      req_to_x     = tx;
      req_to_y     = ty;
      req_position = pos;
      do
         @(posedge clock);
      while (busy);
      issued++;
      @(negedge clock);
      if (issued >= TOTAL_ITEMS - QUIET_ITEMS)
         gap_odds = 0;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic pool_op(input logic [KIND_W-1:0] kind);
      logic signed [COORD_W-1:0] fx, fy, tx, ty;
      pool_segment(fx, fy, tx, ty);
      issue_op(kind, fx, fy, tx, ty, pick_position());
   endtask

   task automatic fresh_op(input logic [KIND_W-1:0] kind);
      issue_op(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord(), pick_position());
   endtask

   // clear now and then, then many new segments: drives the list into the full case
   task automatic fill_burst();
      int n;
      int r;
      if ($urandom_range(0, 1) == 0)
         issue_op(KIND_CLEAR, '0, '0, '0, '0, '0);
      n = $urandom_range(40, 72);
      repeat (n) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            fresh_op(KIND_INSERT);
         else if (r == 1)
            pool_op(KIND_APPEND);
         else if (r == 2)
            pool_op(KIND_INSERT);
         else
            fresh_op(KIND_APPEND);
      end
   endtask

   // every operation on a shared pool of points
   task automatic mixed_burst();
      int r;
      refill_pool();
      repeat ($urandom_range(20, 40)) begin
         r = $urandom_range(0, 39);
         if (r < 12)
            pool_op(KIND_APPEND);
         else if (r < 20)
            pool_op(KIND_INSERT);
         else if (r < 27)
            pool_op(KIND_REMOVE_AT);
         else if (r < 37)
            pool_op(KIND_REMOVE);
         else if (r < 38)
            pool_op(KIND_CLEAR);
         else
            pool_op(KIND_W'(KIND_SPARE_FIRST +
                            $urandom_range(0, KIND_SPARE_LAST - KIND_SPARE_FIRST)));
      end
   endtask

   task automatic drain_burst();
      repeat ($urandom_range(10, 30)) begin
         if ($urandom_range(0, 1) == 0)
            pool_op(KIND_REMOVE_AT);
         else
            pool_op(KIND_REMOVE);
      end
   endtask

   // fully random words, any kind code
   task automatic noise_burst();
      repeat ($urandom_range(5, 15))
         issue_op(KIND_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom), POS_W'($urandom));
   endtask

   initial begin
      int r;
      reset        = 1'b1;
      start        = 1'b0;
      req_kind     = KIND_APPEND;
      req_from_x   = '0;
      req_from_y   = '0;
      req_to_x     = '0;
      req_to_y     = '0;
      req_position = '0;
      refill_pool();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, extremes, reversal, degenerate segment, bad indexes
      issue_op(KIND_CLEAR, '0, '0, '0, '0, '0);
      issue_op(KIND_REMOVE_AT, '0, '0, '0, '0, '0);
      issue_op(KIND_REMOVE, 16'sh0001, 16'sh0002, 16'sh0003, 16'sh0004, '0);
      issue_op(KIND_INSERT, 16'sh0001, 16'sh0002, 16'sh0003, 16'sh0004, '0);
      issue_op(KIND_APPEND, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, '0);
      issue_op(KIND_APPEND, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, '0);
      issue_op(KIND_APPEND, 16'sh0000, 16'sh0000, 16'sh0001, 16'shffff, '0);
      issue_op(KIND_INSERT, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, '0);
      issue_op(KIND_INSERT, 16'sh0001, 16'shffff, 16'sh0000, 16'sh0000, 6'd1);
      issue_op(KIND_INSERT, 16'sh1234, 16'sh5678, 16'sh1234, 16'sh5678, 6'd63);
      issue_op(KIND_INSERT, 16'sh1234, 16'sh5678, 16'sh1234, 16'sh5678, 6'd2);
      issue_op(KIND_APPEND, 16'sh1234, 16'sh5678, 16'sh1234, 16'sh5678, '0);
      issue_op(KIND_REMOVE, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, '0);
      issue_op(KIND_REMOVE, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, '0);
      issue_op(KIND_REMOVE_AT, '0, '0, '0, '0, 6'd3);
      issue_op(KIND_REMOVE_AT, '0, '0, '0, '0, 6'd1);
      issue_op(KIND_SPARE_FIRST, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 6'd63);
      issue_op(KIND_SPARE_FIRST + 3'd1, '0, '0, '0, '0, '0);
      issue_op(KIND_SPARE_LAST, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 6'd42);
      issue_op(KIND_CLEAR, '0, '0, '0, '0, 6'd63);
      issue_op(KIND_REMOVE_AT, '0, '0, '0, '0, '0);

      // random bursts of varied character and idle density
      while (issued < TOTAL_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       gap_odds = 0;
            1:       gap_odds = 2;
            default: gap_odds = 4;
         endcase
         r = $urandom_range(0, 19);
         if (r < 4)
            fill_burst();
         else if (r < 13)
            mixed_burst();
         else if (r < 17)
            drain_burst();
         else
            noise_burst();
      end
      start = 1'b0;

      // drain and let the block settle
      while (outstanding != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
design/usl_pkg.sv
design/usl_seg_mem.sv
design/undirected_segment_list.sv
bench/segment_list_checker.sv
bench/testbench.sv
